// File: sv/indexed_array_list_engine_core_assert.svh
// Assertion macros used by the checker file.
`ifndef INDEXED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IALE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IALE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/iale_pkg.sv
`default_nettype none

package iale_pkg;

   // Store geometry
   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = 6;
   localparam int CNT_W      = 7;
   localparam int KIND_W     = 3;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SELECT  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REPLACE = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [CNT_W-1:0]      position;
      logic [DATA_WIDTH-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [DATA_WIDTH-1:0] read_value;
      logic [CNT_W-1:0]      found_at;
      logic [CNT_W-1:0]      entry_count;
      logic                  is_empty;
      logic                  is_full;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

// File: sv/iale_ctrl.sv
`default_nettype none

module iale_ctrl import iale_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  logic    walk_done,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Sequence one request: take it, walk the store, commit the result
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (walk_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until the transfer completes
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/iale_dp.sv
`default_nettype none

module iale_dp import iale_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output logic             walk_done,
   output rsp_type          rsp_data
);

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pend_ff, pend_in;
   logic                  found_ff, found_in;

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic                  ok_ff, ok_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic                  up_ff, up_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0]     found_idx_ff, found_idx_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [CNT_W-1:0]      limit;
   logic                  dec_ok;
   logic [CNT_W-1:0]      dec_left;
   logic [CNT_W-1:0]      dec_ptr;
   logic                  dec_up;
   logic                  is_insert, is_remove, is_search, is_select, is_replace;
   logic                  hit, issue;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [CNT_W-1:0]      cnt_new;

   // Clamp the programmed limit to the store depth
   assign limit = (cap_ff > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : cap_ff;

   assign is_insert  = (kind_ff == KIND_INSERT);
   assign is_remove  = (kind_ff == KIND_REMOVE);
   assign is_search  = (kind_ff == KIND_SEARCH);
   assign is_select  = (kind_ff == KIND_SELECT);
   assign is_replace = (kind_ff == KIND_REPLACE);

   // Decode the incoming request against the current count
   always_comb begin
      dec_ok   = 1'b0;
      dec_left = '0;
      dec_ptr  = '0;
      dec_up   = 1'b1;
      unique case (req_data.kind)
         KIND_INSERT: begin
            dec_ok = (count_ff < limit) && (req_data.position <= count_ff);
            if (dec_ok) begin
               dec_left = count_ff - req_data.position;
            end
            dec_ptr = count_ff - CNT_W'(1);
            dec_up  = 1'b0;
         end
         KIND_REMOVE: begin
            dec_ok = (count_ff != '0) && (req_data.position < count_ff);
            if (dec_ok) begin
               dec_left = count_ff - req_data.position - CNT_W'(1);
            end
            dec_ptr = req_data.position + CNT_W'(1);
         end
         KIND_SEARCH: begin
            dec_ok   = 1'b1;
            dec_left = count_ff;
         end
         KIND_SELECT: begin
            dec_ok = (count_ff != '0);
            if (dec_ok) begin
               dec_left = CNT_W'(1);
            end
            dec_ptr = (req_data.position < count_ff) ? req_data.position
                                                     : count_ff - CNT_W'(1);
         end
         KIND_REPLACE: begin
            dec_ok  = (count_ff != '0) && (req_data.position < count_ff);
            dec_ptr = req_data.position;
         end
         default: begin
            dec_ok = 1'b0;
         end
      endcase
   end

   // Walk: issue one store read per cycle, act on it the cycle after
   assign hit       = pend_ff && is_search && (rd_data_ff == val_ff);
   assign issue     = cmd.step && (left_ff != '0) && !found_ff && !hit;
   assign walk_done = !pend_ff && ((left_ff == '0) || found_ff);

   // Store write: shift moves during the walk, final write at commit
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = rd_data_ff;
      if (pend_ff && (is_insert || is_remove)) begin
         wr_en   = 1'b1;
         wr_addr = is_insert ? pend_addr_ff + ADDR_W'(1) : pend_addr_ff - ADDR_W'(1);
      end else if (cmd.commit && ok_ff && (is_insert || is_replace)) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff[ADDR_W-1:0];
         wr_data = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   // Count after the request
   always_comb begin
      cnt_new = count_ff;
      if (ok_ff && is_insert) begin
         cnt_new = count_ff + CNT_W'(1);
      end else if (ok_ff && is_remove) begin
         cnt_new = count_ff - CNT_W'(1);
      end
   end

   // Build the result word
   always_comb begin
      rsp_in.ok          = ok_ff;
      rsp_in.read_value  = (is_select && ok_ff) ? rd_data_ff : '0;
      rsp_in.found_at    = '0;
      if (is_search) begin
         rsp_in.found_at = found_ff ? CNT_W'(found_idx_ff) : count_ff;
      end
      rsp_in.entry_count = cnt_new;
      rsp_in.is_empty    = (cnt_new == '0);
      rsp_in.is_full     = (cnt_new >= limit);
   end

   // Next-state values for control and payload registers
   always_comb begin
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      count_in     = cmd.commit ? cnt_new : count_ff;
      pend_in      = issue;
      pend_addr_in = issue ? ptr_ff : pend_addr_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      left_in      = left_ff;
      ptr_in       = ptr_ff;
      up_in        = up_ff;
      if (cmd.load) begin
         kind_in  = req_data.kind;
         pos_in   = req_data.position;
         val_in   = req_data.item_value;
         ok_in    = dec_ok;
         left_in  = dec_left;
         ptr_in   = dec_ptr[ADDR_W-1:0];
         up_in    = dec_up;
         found_in = 1'b0;
      end else begin
         if (issue) begin
            left_in = left_ff - CNT_W'(1);
            ptr_in  = up_ff ? ptr_ff + ADDR_W'(1) : ptr_ff - ADDR_W'(1);
         end
         if (hit) begin
            found_in     = 1'b1;
            found_idx_in = pend_addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CNT_W'(CAPACITY);
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      ok_ff        <= ok_in;
      left_ff      <= left_in;
      ptr_ff       <= ptr_in;
      up_ff        <= up_in;
      pend_addr_ff <= pend_addr_in;
      found_idx_ff <= found_idx_in;
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: sv/indexed_array_list_engine_core.sv
// Store reads per request: insert count - position, remove count - position - 1,
//   search up to count, select 1; refused, replace and unknown kinds read nothing.
// Requests are taken one at a time, the next accepted in the cycle after commit;
//   the store walk and result stalls set the pace.
// Reset: synchronous; clears count, control and sets the limit to 64. Store not cleared.
`default_nettype none

module indexed_array_list_engine_core import iale_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   cmd_type cmd;
   logic    walk_done;

   // Sequence requests
   iale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .walk_done (walk_done),
      .cmd       (cmd)
   );

   // Store, count and result register
   iale_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .walk_done   (walk_done),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// File: sv/iale_checker.sv
`default_nettype none

`include "indexed_array_list_engine_core_assert.svh"

module iale_checker import iale_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Hold a stalled result
   `IALE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // One request in flight: stall right after a transfer
   `IALE_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

   // Empty flag follows the count
   `IALE_ASSERT_IMP(a_empty_flag, clock, reset, rsp_valid, rsp_data.is_empty == (rsp_data.entry_count == '0), "empty flag disagrees with count")

   // Count never exceeds the store depth
   `IALE_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_data.entry_count <= CNT_W'(CAPACITY), "count beyond store depth")

endmodule

bind indexed_array_list_engine_core iale_checker u_iale_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
